/* rtl/core/light_curve_residual_unit_macros.svh */
// ============================================================================
// light_curve_residual_unit_macros.svh
// Assertion helpers used by the light curve residual RTL.
// ============================================================================
`ifndef LIGHT_CURVE_RESIDUAL_UNIT_MACROS_SVH
`define LIGHT_CURVE_RESIDUAL_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define LCR_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define LCR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lcr_pkg.sv */
// ============================================================================
// lcr_pkg
// Shared types, codes and constants of the light curve residual unit.
// ============================================================================
package lcr_pkg;

    // Observation request
    typedef struct packed {
        logic signed [31:0] obs_time;
        logic signed [31:0] observed_flux;
        logic        [30:0] flux_sigma;
    } lcr_in_t;

    // Result request
    typedef struct packed {
        logic signed [31:0] model_flux;
        logic signed [31:0] norm_residual;
        logic        [1:0]  status;
    } lcr_out_t;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NEG_MODEL  = 2'd1;
    localparam logic [1:0] STATUS_NONPOS_OBS = 2'd2;
    localparam logic [1:0] STATUS_SATURATED  = 2'd3;

    // Register indexes
    localparam logic [1:0] CFG_AMPLITUDE      = 2'd0;
    localparam logic [1:0] CFG_RISE_TIME      = 2'd1;
    localparam logic [1:0] CFG_FALL_TIME      = 2'd2;
    localparam logic [1:0] CFG_REFERENCE_TIME = 2'd3;

    localparam int CFG_W  = 27;
    localparam int TIME_W = 23;

    localparam logic signed [26:0] AMPLITUDE_RST = 27'sd65536;
    localparam logic [22:0]        RISE_RST      = 23'd327680;
    localparam logic [22:0]        FALL_RST      = 23'd6488064;
    localparam logic [22:0]        REF_RST       = 23'd3866624;

    // Exponential unit
    localparam int W_W = 24;   // clamped exponent argument, Q8.16 signed
    localparam int E_W = 60;   // e^w in Q30, up to 2^59
    localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;
    localparam logic signed [23:0] W_MAX     = 24'sd4194304;   //  64.0
    localparam logic signed [23:0] W_MIN     = -24'sd4194304;  // -64.0
    localparam logic signed [25:0] V_MAX     = 26'sd1835008;   //  28.0
    localparam logic signed [25:0] V_MIN     = -26'sd2621440;  // -40.0

    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

    // Integer square root, used only on constants
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = x;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q30, built by repeated square roots from 2.0
    function automatic logic [31:0] exp_root_coef(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 0; i < 16; i++)
        begin
            if (i < k)
                c = isqrt64(c << 30);
        end
        return c[31:0];
    endfunction

endpackage

/* rtl/core/light_curve_residual_unit.sv */
// ============================================================================
// light_curve_residual_unit
// Rise-and-fall light curve model flux and normalized residual per observation.
// ============================================================================
//
//  channel   dir   handshake             request
//  --------  ----  --------------------  -----------------------------------
//  in        in    in_valid / in_stall   obs_time, observed_flux, flux_sigma
//  out       out   out_valid / out_stall model_flux, norm_residual, status
//  cfg       in    cfg_we                cfg_index, cfg_data
//
//  One observation per cycle while in_stall is low; most of the pipeline depth
//  is in the four bit-per-stage dividers (48 + 30 + 27 + 48 stages).
//  All stages move together; the pipeline holds only while a result waits in
//  the output register under out_stall, and in_stall follows that condition.
//  rst_n clears every valid bit and loads the register reset values.
//  Registers are to be written only while the pipeline is empty; the block itself does not enforce it.
//
`include "light_curve_residual_unit_macros.svh"

module light_curve_residual_unit #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lcr_pkg::lcr_in_t               in_req,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lcr_pkg::lcr_out_t              out_req,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [lcr_pkg::CFG_W-1:0]      cfg_data
);

    typedef struct packed {
        logic signed [31:0] y;
        logic        [30:0] sigma;
    } obs_side_t;

    typedef struct packed {
        logic              dneg;
        logic              dpos;
    } dsign_t;

    typedef struct packed {
        logic [56:0] absq;
        obs_side_t   obs;
    } flux_side_t;

    typedef struct packed {
        logic signed [31:0] flux;
        logic               fixed;
        logic signed [31:0] fixed_res;
        logic [1:0]         status;
        logic               rneg;
    } res_side_t;

    localparam int OBS_W  = $bits(obs_side_t);
    localparam int DS_W   = $bits(dsign_t);
    localparam int FS_W   = $bits(flux_side_t);
    localparam int RS_W   = $bits(res_side_t);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [26:0] amp_reg;
    logic [22:0]        rise_reg;
    logic [22:0]        fall_reg;
    logic [22:0]        ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg  <= lcr_pkg::AMPLITUDE_RST;
            rise_reg <= lcr_pkg::RISE_RST;
            fall_reg <= lcr_pkg::FALL_RST;
            ref_reg  <= lcr_pkg::REF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcr_pkg::CFG_AMPLITUDE:      amp_reg  <= cfg_data;
                lcr_pkg::CFG_RISE_TIME:      rise_reg <= cfg_data[22:0];
                lcr_pkg::CFG_FALL_TIME:      fall_reg <= cfg_data[22:0];
                lcr_pkg::CFG_REFERENCE_TIME: ref_reg  <= cfg_data[22:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: hold only while the output register is blocked
    // ------------------------------------------------------------------
    logic              adv;
    logic              out_valid_reg;
    lcr_pkg::lcr_out_t out_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // Front stage: d = t0 - t, magnitude scaled to Q16.16 dividend
    // ------------------------------------------------------------------
    logic signed [32:0] d;
    logic [32:0]        d_mag;
    logic               f_vld_reg;
    logic [47:0]        f_num_reg;
    logic [22:0]        f_rise_reg;
    logic [22:0]        f_fall_reg;
    obs_side_t          f_obs_reg;
    dsign_t             f_ds_reg;

    assign d     = $signed({10'd0, ref_reg}) - {in_req.obs_time[31], in_req.obs_time};
    assign d_mag = d[32] ? 33'(-d) : d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (adv)
            f_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_num_reg      <= {d_mag[31:0], 16'd0};
            f_rise_reg     <= (rise_reg == '0) ? 23'd1 : rise_reg;
            f_fall_reg     <= (fall_reg == '0) ? 23'd1 : fall_reg;
            f_obs_reg.y    <= in_req.observed_flux;
            f_obs_reg.sigma <= in_req.flux_sigma;
            f_ds_reg.dneg  <= d[32];
            f_ds_reg.dpos  <= !d[32] && (d != '0);
        end
    end

    // ------------------------------------------------------------------
    // |d| / Trise and |d| / Tfall
    // ------------------------------------------------------------------
    logic               dr_vld;
    logic               dfl_vld;
    logic [47:0]        q_rise;
    logic [47:0]        q_fall;
    logic [OBS_W-1:0]   dr_side;
    logic [DS_W-1:0]    dfl_side;

    lcr_div_pipe #(
        .NUM_W (48),
        .DEN_W (23),
        .Q_W   (48),
        .SIDE_W(OBS_W)
    ) u_div_rise (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (f_vld_reg),
        .in_num   (f_num_reg),
        .in_den   (f_rise_reg),
        .in_side  (f_obs_reg),
        .out_valid(dr_vld),
        .out_quo  (q_rise),
        .out_rem  (),
        .out_den  (),
        .out_side (dr_side)
    );

    lcr_div_pipe #(
        .NUM_W (48),
        .DEN_W (23),
        .Q_W   (48),
        .SIDE_W(DS_W)
    ) u_div_fall (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (f_vld_reg),
        .in_num   (f_num_reg),
        .in_den   (f_fall_reg),
        .in_side  (f_ds_reg),
        .out_valid(dfl_vld),
        .out_quo  (q_fall),
        .out_rem  (),
        .out_den  (),
        .out_side (dfl_side)
    );

    // ------------------------------------------------------------------
    // Exponent arguments: pick the stable form by sign of d, then clamp
    // ------------------------------------------------------------------
    dsign_t             ds;
    logic signed [49:0] ur;
    logic signed [49:0] uf;
    logic signed [49:0] wn_raw;
    logic signed [49:0] wd_raw;
    logic signed [23:0] wn;
    logic signed [23:0] wd;
    logic               w_vld_reg;
    logic signed [23:0] w_n_reg;
    logic signed [23:0] w_d_reg;
    obs_side_t          w_obs_reg;

    assign ds     = dfl_side;
    assign ur     = ds.dneg ? -$signed({2'b00, q_rise}) : $signed({2'b00, q_rise});
    assign uf     = ds.dneg ? -$signed({2'b00, q_fall}) : $signed({2'b00, q_fall});
    assign wn_raw = ds.dpos ? (uf - ur) : uf;
    assign wd_raw = ds.dpos ? -ur : ur;

    always_comb
    begin
        if (wn_raw > 50'(lcr_pkg::W_MAX))
            wn = lcr_pkg::W_MAX;
        else if (wn_raw < 50'(lcr_pkg::W_MIN))
            wn = lcr_pkg::W_MIN;
        else
            wn = wn_raw[23:0];

        if (wd_raw > 50'(lcr_pkg::W_MAX))
            wd = lcr_pkg::W_MAX;
        else if (wd_raw < 50'(lcr_pkg::W_MIN))
            wd = lcr_pkg::W_MIN;
        else
            wd = wd_raw[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_vld_reg <= 1'b0;
        else if (adv)
            w_vld_reg <= dr_vld && dfl_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_n_reg   <= wn;
            w_d_reg   <= wd;
            w_obs_reg <= dr_side;
        end
    end

    // ------------------------------------------------------------------
    // Numerator and denominator exponentials
    // ------------------------------------------------------------------
    logic                    ex_vld;
    logic [lcr_pkg::E_W-1:0] e_num;
    logic [lcr_pkg::E_W-1:0] e_den;
    logic [OBS_W-1:0]        ex_side;

    lcr_exp_pipe #(
        .TABLE_BITS(EXP_TABLE_BITS),
        .SIDE_W    (OBS_W)
    ) u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (w_vld_reg),
        .in_w_num (w_n_reg),
        .in_w_den (w_d_reg),
        .in_side  (w_obs_reg),
        .out_valid(ex_vld),
        .out_e_num(e_num),
        .out_e_den(e_den),
        .out_side (ex_side)
    );

    // den = 1.0 + E
    logic                    n_vld_reg;
    logic [lcr_pkg::E_W-1:0] n_num_reg;
    logic [60:0]             n_den_reg;
    obs_side_t               n_obs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_vld_reg <= 1'b0;
        else if (adv)
            n_vld_reg <= ex_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_num_reg <= e_num;
            n_den_reg <= 61'(e_den) + (61'd1 << 30);
            n_obs_reg <= ex_side;
        end
    end

    // ------------------------------------------------------------------
    // q = num / den, r = num % den
    // ------------------------------------------------------------------
    logic             q_vld;
    logic [29:0]      q_main;
    logic [60:0]      r_main;
    logic [60:0]      q_den;
    logic [OBS_W-1:0] q_side;

    lcr_div_pipe #(
        .NUM_W (lcr_pkg::E_W),
        .DEN_W (61),
        .Q_W   (30),
        .SIDE_W(OBS_W)
    ) u_div_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (n_vld_reg),
        .in_num   (n_num_reg),
        .in_den   (n_den_reg),
        .in_side  (n_obs_reg),
        .out_valid(q_vld),
        .out_quo  (q_main),
        .out_rem  (r_main),
        .out_den  (q_den),
        .out_side (q_side)
    );

    // ------------------------------------------------------------------
    // |A| * q and |A| * r as partial products
    // ------------------------------------------------------------------
    logic [26:0] absa;
    logic        m_vld_reg;
    logic [56:0] m_absq_reg;
    logic [57:0] m_plo_reg;
    logic [56:0] m_phi_reg;
    logic [60:0] m_den_reg;
    obs_side_t   m_obs_reg;

    assign absa = amp_reg[26] ? 27'(-amp_reg) : amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (adv)
            m_vld_reg <= q_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_absq_reg <= 57'(absa) * 57'(q_main);
            m_plo_reg  <= 58'(absa) * 58'(r_main[30:0]);
            m_phi_reg  <= 57'(absa) * 57'(r_main[60:31]);
            m_den_reg  <= q_den;
            m_obs_reg  <= q_side;
        end
    end

    logic       a_vld_reg;
    logic [87:0] a_prod_reg;
    logic [60:0] a_den_reg;
    flux_side_t  a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= m_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_prod_reg      <= 88'(m_plo_reg) + (88'(m_phi_reg) << 31);
            a_den_reg       <= m_den_reg;
            a_side_reg.absq <= m_absq_reg;
            a_side_reg.obs  <= m_obs_reg;
        end
    end

    // |A| * r / den, quotient below |A|
    logic             c_vld;
    logic [26:0]      c_quo;
    logic [FS_W-1:0]  c_side_raw;
    flux_side_t       c_side;

    lcr_div_pipe #(
        .NUM_W (88),
        .DEN_W (61),
        .Q_W   (27),
        .SIDE_W(FS_W)
    ) u_div_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (a_vld_reg),
        .in_num   (a_prod_reg),
        .in_den   (a_den_reg),
        .in_side  (a_side_reg),
        .out_valid(c_vld),
        .out_quo  (c_quo),
        .out_rem  (),
        .out_den  (),
        .out_side (c_side_raw)
    );

    assign c_side = c_side_raw;

    // ------------------------------------------------------------------
    // Model flux with sign of A, saturated to int32
    // ------------------------------------------------------------------
    logic [57:0]        mag;
    logic signed [31:0] flux_next;
    logic               sat_next;
    logic               x_vld_reg;
    logic signed [31:0] x_flux_reg;
    logic               x_sat_reg;
    obs_side_t          x_obs_reg;

    assign mag = 58'(c_side.absq) + 58'(c_quo);

    always_comb
    begin
        if (amp_reg[26])
        begin
            sat_next  = (mag > 58'h8000_0000);
            flux_next = sat_next ? lcr_pkg::I32_MIN : 32'(32'd0 - mag[31:0]);
        end
        else
        begin
            sat_next  = (mag > 58'h7FFF_FFFF);
            flux_next = sat_next ? lcr_pkg::I32_MAX : mag[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x_vld_reg <= 1'b0;
        else if (adv)
            x_vld_reg <= c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_flux_reg <= flux_next;
            x_sat_reg  <= sat_next;
            x_obs_reg  <= c_side.obs;
        end
    end

    // ------------------------------------------------------------------
    // Residual set-up: special cases, |y - F| scaled to Q16.16
    // ------------------------------------------------------------------
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic               y_pos;
    res_side_t          rs_next;
    logic               r_vld_reg;
    logic [47:0]        r_num_reg;
    logic [30:0]        r_den_reg;
    res_side_t          r_side_reg;

    assign diff     = {x_obs_reg.y[31], x_obs_reg.y} - {x_flux_reg[31], x_flux_reg};
    assign diff_mag = diff[32] ? 33'(-diff) : diff;
    assign y_pos    = !x_obs_reg.y[31] && (x_obs_reg.y != '0);

    always_comb
    begin
        rs_next.flux      = x_flux_reg;
        rs_next.rneg      = diff[32];
        rs_next.fixed     = 1'b1;
        rs_next.fixed_res = lcr_pkg::I32_MAX;
        rs_next.status    = lcr_pkg::STATUS_NEG_MODEL;
        priority if (x_flux_reg[31])
        begin
            rs_next.fixed_res = lcr_pkg::I32_MAX;
            rs_next.status    = lcr_pkg::STATUS_NEG_MODEL;
        end
        else if (!y_pos)
        begin
            rs_next.fixed_res = '0;
            rs_next.status    = lcr_pkg::STATUS_NONPOS_OBS;
        end
        else if (x_obs_reg.sigma == '0)
        begin
            rs_next.fixed_res = lcr_pkg::I32_MAX;
            rs_next.status    = lcr_pkg::STATUS_SATURATED;
        end
        else
        begin
            rs_next.fixed  = 1'b0;
            rs_next.status = x_sat_reg ? lcr_pkg::STATUS_SATURATED : lcr_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_vld_reg <= 1'b0;
        else if (adv)
            r_vld_reg <= x_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_num_reg  <= {diff_mag[31:0], 16'd0};
            r_den_reg  <= rs_next.fixed ? 31'd1 : x_obs_reg.sigma;
            r_side_reg <= rs_next;
        end
    end

    // (y - F) / sigma on magnitudes
    logic             z_vld;
    logic [47:0]      z_quo;
    logic [RS_W-1:0]  z_side_raw;
    res_side_t        z_side;

    lcr_div_pipe #(
        .NUM_W (48),
        .DEN_W (31),
        .Q_W   (48),
        .SIDE_W(RS_W)
    ) u_div_resid (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (r_vld_reg),
        .in_num   (r_num_reg),
        .in_den   (r_den_reg),
        .in_side  (r_side_reg),
        .out_valid(z_vld),
        .out_quo  (z_quo),
        .out_rem  (),
        .out_den  (),
        .out_side (z_side_raw)
    );

    assign z_side = z_side_raw;

    // ------------------------------------------------------------------
    // Output register: sign, saturation, final status
    // ------------------------------------------------------------------
    lcr_pkg::lcr_out_t out_next;

    always_comb
    begin
        out_next.model_flux    = z_side.flux;
        out_next.norm_residual = z_side.fixed_res;
        out_next.status        = z_side.status;
        if (!z_side.fixed)
        begin
            if (z_side.rneg)
            begin
                if (z_quo > 48'h8000_0000)
                begin
                    out_next.norm_residual = lcr_pkg::I32_MIN;
                    out_next.status        = lcr_pkg::STATUS_SATURATED;
                end
                else
                begin
                    out_next.norm_residual = 32'(32'd0 - z_quo[31:0]);
                end
            end
            else
            begin
                if (z_quo > 48'h7FFF_FFFF)
                begin
                    out_next.norm_residual = lcr_pkg::I32_MAX;
                    out_next.status        = lcr_pkg::STATUS_SATURATED;
                end
                else
                begin
                    out_next.norm_residual = z_quo[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= z_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `LCR_CHECK(a_neg_status_has_neg_flux,
        out_valid && (out_req.status == lcr_pkg::STATUS_NEG_MODEL), out_req.model_flux[31],
        "negative-model status with nonnegative flux")
    `LCR_CHECK(a_neg_flux_has_neg_status,
        out_valid && out_req.model_flux[31], out_req.status == lcr_pkg::STATUS_NEG_MODEL,
        "negative flux without negative-model status")
    `LCR_CHECK(a_nonpos_zero_residual,
        out_valid && (out_req.status == lcr_pkg::STATUS_NONPOS_OBS),
        out_req.norm_residual == '0, "nonpositive observation with nonzero residual")
    `LCR_CHECK_NEXT(a_no_spurious_result, !out_valid_reg && !z_vld, !out_valid_reg,
        "result appeared with nothing in the last stage")

endmodule

/* rtl/core/lcr_div_pipe.sv */
// ============================================================================
// lcr_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ============================================================================
module lcr_div_pipe #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 23,
    parameter int Q_W    = 48,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    // Upper dividend bits start as the partial remainder; caller keeps it below in_den
    localparam int EXT_W = NUM_W + DEN_W;

    logic [EXT_W-1:0] num_ext;
    logic [DEN_W-1:0] init_rem;

    assign num_ext  = {{DEN_W{1'b0}}, in_num};
    assign init_rem = DEN_W'(num_ext >> Q_W);

    logic              vld_reg  [Q_W];
    logic [DEN_W-1:0]  rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    bits_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic              vld_prev;
        logic [DEN_W-1:0]  rem_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [Q_W-1:0]    bits_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [Q_W-1:0]    bits_next;

        if (s == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = init_rem;
            assign den_prev  = in_den;
            assign bits_prev = Q_W'(in_num);
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign bits_prev = bits_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        assign trial     = {rem_prev, bits_prev[Q_W-1]};
        assign diff      = trial - {1'b0, den_prev};
        assign ge        = (trial >= {1'b0, den_prev});
        assign rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign bits_next = {bits_prev[Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_prev;
                bits_reg[s] <= bits_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = bits_reg[Q_W-1];
    assign out_rem   = rem_reg[Q_W-1];
    assign out_den   = den_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

/* rtl/core/lcr_exp_pipe.sv */
// ============================================================================
// lcr_exp_pipe
// Two-lane pipelined e^w in Q30: log2(e) scale, then one root factor per stage.
// ============================================================================
module lcr_exp_pipe #(
    parameter int TABLE_BITS = 8,
    parameter int SIDE_W     = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [lcr_pkg::W_W-1:0]  in_w_num,
    input  logic signed [lcr_pkg::W_W-1:0]  in_w_den,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic [lcr_pkg::E_W-1:0]         out_e_num,
    output logic [lcr_pkg::E_W-1:0]         out_e_den,
    output logic [SIDE_W-1:0]               out_side
);

    // scale, split, TABLE_BITS factor stages, final shift
    localparam int DEPTH = TABLE_BITS + 3;
    localparam int PR_W  = lcr_pkg::W_W + 18;

    logic              vld_reg  [DEPTH];
    logic [SIDE_W-1:0] side_reg [DEPTH];

    logic signed [lcr_pkg::W_W-1:0] w_in [2];

    logic signed [PR_W-1:0]       prod_reg [2];
    logic signed [6:0]            n_reg    [2][TABLE_BITS+1];
    logic [TABLE_BITS-1:0]        idx_reg  [2][TABLE_BITS+1];
    logic [31:0]                  m_reg    [2][TABLE_BITS+1];
    logic [lcr_pkg::E_W-1:0]      e_reg    [2];

    assign w_in[0] = in_w_num;
    assign w_in[1] = in_w_den;

    // Valid and sideband travel with the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < DEPTH; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < DEPTH; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [25:0] v;
        logic signed [25:0] vc;
        logic [6:0]         n_neg;

        // w * log2(e)
        always_ff @(posedge clk)
        begin
            if (en)
                prod_reg[l] <= PR_W'(w_in[l]) * PR_W'(lcr_pkg::LOG2E_Q16);
        end

        // floor to Q16.16, clamp, split into shift and table index
        assign v = prod_reg[l][PR_W-1:16];

        always_comb
        begin
            if (v > lcr_pkg::V_MAX)
                vc = lcr_pkg::V_MAX;
            else if (v < lcr_pkg::V_MIN)
                vc = lcr_pkg::V_MIN;
            else
                vc = v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[l][0]   <= vc[22:16];
                idx_reg[l][0] <= vc[15:16-TABLE_BITS];
                m_reg[l][0]   <= 32'd1 << 30;
            end
        end

        // One root factor per stage, rounded back to Q30
        for (genvar k = 1; k <= TABLE_BITS; k++)
        begin : g_fac
            localparam logic [31:0] COEF = lcr_pkg::exp_root_coef(k);
            logic [63:0] mul;
            logic [63:0] rnd;
            logic [31:0] m_next;

            assign mul    = {32'd0, m_reg[l][k-1]} * {32'd0, COEF};
            assign rnd    = (mul + (64'd1 << 29)) >> 30;
            assign m_next = idx_reg[l][k-1][TABLE_BITS-k] ? rnd[31:0] : m_reg[l][k-1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[l][k]   <= m_next;
                    n_reg[l][k]   <= n_reg[l][k-1];
                    idx_reg[l][k] <= idx_reg[l][k-1];
                end
            end
        end

        // Apply the integer power of two
        assign n_neg = 7'(-n_reg[l][TABLE_BITS]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!n_reg[l][TABLE_BITS][6])
                    e_reg[l] <= lcr_pkg::E_W'(m_reg[l][TABLE_BITS]) << n_reg[l][TABLE_BITS][4:0];
                else
                    e_reg[l] <= lcr_pkg::E_W'(m_reg[l][TABLE_BITS]) >> n_neg[5:0];
            end
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_side  = side_reg[DEPTH-1];
    assign out_e_num = e_reg[0];
    assign out_e_den = e_reg[1];

endmodule

/* tb/light_curve_residual_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// light_curve_residual_checker
// Watches the observation, result and register ports of the light curve
// residual unit. It keeps its own copy of the registers, predicts the result
// of every accepted observation, and checks results in order, field by field.
// ============================================================================
module light_curve_residual_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  lcr_pkg::lcr_in_t          in_req,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  lcr_pkg::lcr_out_t         out_req,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [lcr_pkg::CFG_W-1:0] cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        checked
);

    localparam int TBL_BITS = 8;

    // register mirror
    logic signed [26:0] amp_q;
    logic [22:0]        rise_q;
    logic [22:0]        fall_q;
    logic [22:0]        t0_q;

    logic [63:0]       root_coef [1:TBL_BITS];
    lcr_pkg::lcr_out_t flux_fifo [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    initial
    begin
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int k = 1; k <= TBL_BITS; k++)
        begin
            c = int_sqrt(c << 30);
            root_coef[k] = c;
        end
    end

    // e^w with w in Q16.16, result in Q30
    function automatic logic [63:0] exp_q30(input logic signed [63:0] w);
        logic signed [63:0] v;
        logic signed [63:0] n;
        logic signed [63:0] f;
        logic [63:0]        m;
        if (w > 64 * 65536)
            w = 64 * 65536;
        if (w < -64 * 65536)
            w = -64 * 65536;
        v = (w * 94548) >>> 16;
        if (v > 28 * 65536)
            v = 28 * 65536;
        if (v < -40 * 65536)
            v = -40 * 65536;
        n = v >>> 16;
        f = v - (n <<< 16);
        m = 64'd1 << 30;
        for (int k = 1; k <= TBL_BITS; k++)
            if (f[16 - k])
                m = (m * root_coef[k] + (64'd1 << 29)) >> 30;
        return (n >= 0) ? (m << n) : (m >> (-n));
    endfunction

    function automatic lcr_pkg::lcr_out_t curve_residual(input lcr_pkg::lcr_in_t obs);
        logic signed [63:0] t;
        logic signed [63:0] y;
        logic signed [63:0] sig;
        logic signed [63:0] tr;
        logic signed [63:0] tf;
        logic signed [63:0] d;
        logic signed [63:0] ur;
        logic signed [63:0] uf;
        logic signed [63:0] flux;
        logic signed [63:0] res;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        mag;
        logic [63:0]        absa;
        lcr_pkg::lcr_out_t  o;
        o.status = lcr_pkg::STATUS_OK;
        t   = obs.obs_time;
        y   = obs.observed_flux;
        sig = {33'd0, obs.flux_sigma};
        // zero time constant counts as one LSB
        tr  = (rise_q == 0) ? 64'sd1 : {41'd0, rise_q};
        tf  = (fall_q == 0) ? 64'sd1 : {41'd0, fall_q};
        d   = $signed({41'd0, t0_q}) - t;
        ur  = (d * 65536) / tr;
        uf  = (d * 65536) / tf;
        if (d <= 0)
        begin
            num = exp_q30(uf);
            den = (64'd1 << 30) + exp_q30(ur);
        end
        else
        begin
            num = exp_q30(uf - ur);
            den = (64'd1 << 30) + exp_q30(-ur);
        end
        absa = (amp_q < 0) ? 64'(-64'(amp_q)) : 64'(amp_q);
        mag  = absa * (num / den) + (absa * (num % den)) / den;
        // saturate the model flux
        if (amp_q < 0)
        begin
            if (mag > 64'd2147483648)
            begin
                flux     = lcr_pkg::I32_MIN;
                o.status = lcr_pkg::STATUS_SATURATED;
            end
            else
                flux = -$signed(mag);
        end
        else if (mag > 64'd2147483647)
        begin
            flux     = lcr_pkg::I32_MAX;
            o.status = lcr_pkg::STATUS_SATURATED;
        end
        else
            flux = $signed(mag);
        // residual and its special cases
        if (flux < 0)
        begin
            res      = lcr_pkg::I32_MAX;
            o.status = lcr_pkg::STATUS_NEG_MODEL;
        end
        else if (y <= 0)
        begin
            res      = 0;
            o.status = lcr_pkg::STATUS_NONPOS_OBS;
        end
        else if (sig == 0)
        begin
            res      = lcr_pkg::I32_MAX;
            o.status = lcr_pkg::STATUS_SATURATED;
        end
        else
        begin
            res = ((y - flux) * 65536) / sig;
            if (res > lcr_pkg::I32_MAX)
            begin
                res      = lcr_pkg::I32_MAX;
                o.status = lcr_pkg::STATUS_SATURATED;
            end
            else if (res < lcr_pkg::I32_MIN)
            begin
                res      = lcr_pkg::I32_MIN;
                o.status = lcr_pkg::STATUS_SATURATED;
            end
        end
        o.model_flux    = flux[31:0];
        o.norm_residual = res[31:0];
        return o;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, want, got);
        errors++;
    endtask

    assign pending = flux_fifo.size();

    initial
    begin
        errors  = 0;
        checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_q  <= lcr_pkg::AMPLITUDE_RST;
            rise_q <= lcr_pkg::RISE_RST;
            fall_q <= lcr_pkg::FALL_RST;
            t0_q   <= lcr_pkg::REF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcr_pkg::CFG_AMPLITUDE:      amp_q  <= cfg_data;
                lcr_pkg::CFG_RISE_TIME:      rise_q <= cfg_data[22:0];
                lcr_pkg::CFG_FALL_TIME:      fall_q <= cfg_data[22:0];
                lcr_pkg::CFG_REFERENCE_TIME: t0_q   <= cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // predict accepted requests, compare delivered results
    always @(posedge clk)
    begin
        lcr_pkg::lcr_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                flux_fifo.push_back(curve_residual(in_req));
            if (out_valid && !out_stall)
            begin
                if (flux_fifo.size() == 0)
                begin
                    $display("[%0t] result with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    want = flux_fifo.pop_front();
                    checked++;
                    if (out_req.model_flux !== want.model_flux)
                        report("model_flux", want.model_flux, out_req.model_flux);
                    if (out_req.norm_residual !== want.norm_residual)
                        report("norm_residual", want.norm_residual, out_req.norm_residual);
                    if (out_req.status !== want.status)
                        report("status", 32'(want.status), 32'(out_req.status));
                end
            end
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Drives the light curve residual unit through several register settings,
// directed edge cases and random observations, with random gaps and back
// pressure; the checker module predicts and compares every result.
// ============================================================================
module tb;

    localparam int  LATENCY   = 172;
    localparam int  PHASE_N   = 150;
    localparam longint LIMIT  = 600000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    lcr_pkg::lcr_in_t          in_req;
    logic                      out_valid;
    logic                      out_stall;
    lcr_pkg::lcr_out_t         out_req;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [lcr_pkg::CFG_W-1:0] cfg_data;
    int                        errors;
    int                        pending;
    int                        checked;

    // stimulus-side copy of the reference time, used to aim observations
    logic [22:0]        t0_sel;
    bit                 no_idle;
    bit                 hold_req;
    longint             cycles;

    light_curve_residual_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    light_curve_residual_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_req   (out_req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side back pressure, with a long hold-off on request
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_req  = 1'b0;
                for (n = 0; n < 3 * LATENCY; n++)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_obs(input lcr_pkg::lcr_in_t obs);
        int g;
        in_valid <= 1'b1;
        in_req   <= obs;
        do
            @(posedge clk);
        while (in_stall);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_fields(input logic [31:0] t, input logic [31:0] y,
                               input logic [30:0] s);
        lcr_pkg::lcr_in_t obs;
        obs.obs_time      = t;
        obs.observed_flux = y;
        obs.flux_sigma    = s;
        send_obs(obs);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic load_regs(input logic signed [26:0] amp, input logic [22:0] rise,
                             input logic [22:0] fall, input logic [22:0] t0);
        cfg_we    <= 1'b1;
        cfg_index <= lcr_pkg::CFG_AMPLITUDE;
        cfg_data  <= amp;
        @(posedge clk);
        cfg_index <= lcr_pkg::CFG_RISE_TIME;
        cfg_data  <= {4'($urandom_range(0, 15)), rise};
        @(posedge clk);
        cfg_index <= lcr_pkg::CFG_FALL_TIME;
        cfg_data  <= {4'd0, fall};
        @(posedge clk);
        cfg_index <= lcr_pkg::CFG_REFERENCE_TIME;
        cfg_data  <= {4'd0, t0};
        @(posedge clk);
        cfg_we    <= 1'b0;
        t0_sel    = t0;
    endtask

    // random observation, mostly near the curve, sometimes anywhere
    task automatic send_random();
        logic signed [31:0] t;
        logic signed [31:0] y;
        logic        [30:0] s;
        int                 k;
        k = $urandom_range(0, 9);
        if (k < 2)
            t = $urandom;
        else
            t = $signed({9'd0, t0_sel}) + ($signed($urandom) >>> $urandom_range(7, 30));
        k = $urandom_range(0, 9);
        if (k < 2)
            y = $urandom;
        else if (k < 3)
            y = -($urandom >> $urandom_range(0, 31));
        else
            y = $urandom >> $urandom_range(1, 31);
        k = $urandom_range(0, 19);
        if (k == 0)
            s = '0;
        else if (k < 6)
            s = 31'($urandom);
        else
            s = 31'($urandom >> $urandom_range(1, 31));
        send_fields(t, y, s);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_req    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= lcr_pkg::CFG_AMPLITUDE;
        cfg_data  <= '0;
        cycles    <= 0;
        hold_req  = 1'b0;
        no_idle   = 1'b0;
        t0_sel    = lcr_pkg::REF_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edge cases at reset settings
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_fields(32'h7FFF_FFFF, 32'h0001_0000, 31'h0000_0001);
        send_fields({9'd0, lcr_pkg::REF_RST}, 32'h0001_0000, 31'h0001_0000);
        send_fields({9'd0, lcr_pkg::REF_RST}, 32'h0000_0000, 31'h0000_0000);
        send_fields({9'd0, lcr_pkg::REF_RST}, 32'h8000_0000, 31'h0001_0000);
        send_fields({9'd0, lcr_pkg::REF_RST}, 32'h0000_8000, 31'h0000_0000);
        send_fields(32'h0000_0000, 32'h7FFF_FFFF, 31'h0000_0001);
        send_fields(32'h0010_0000, 32'h0000_0001, 31'h7FFF_FFFF);
        send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0000);
        drain();
        // large amplitude, tiny sigma: flux and residual saturation
        load_regs(27'sd65536000, 23'd13107, 23'd6553600, 23'd6553600);
        send_fields(32'h0064_0000, 32'h7FFF_FFFF, 31'h0000_0001);
        send_fields(32'h0000_0000, 32'h0000_0001, 31'h0000_0001);
        send_fields(32'h8000_0000, 32'h0001_0000, 31'h0000_0001);
        drain();
        // negative amplitude gives a negative model
        load_regs(-27'sd65536000, 23'd6553600, 23'd1, 23'd0);
        send_fields(32'h0000_0000, 32'h0001_0000, 31'h0001_0000);
        send_fields(32'hFFFF_0000, 32'h0001_0000, 31'h0000_0000);
        send_fields(32'h8000_0000, 32'h8000_0000, 31'h0001_0000);
        drain();

        // random phases through several settings
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: load_regs(27'sd65536000, 23'd13107, 23'd6553600, 23'd6553600);
                1: load_regs(-27'sd65536000, 23'd6553600, 23'd1, 23'd0);
                2: load_regs(27'sd1966080, 23'd0, 23'd0, 23'd3866624);
                3: load_regs(-27'sd65536, 23'd327680, 23'd6488064, 23'd100000);
                4: load_regs(27'sd3276800, 23'd65536, 23'd655360, 23'd3276800);
                5: load_regs(27'sd65536, 23'd327680, 23'd6488064, 23'd3866624);
                default: load_regs(27'(int'($urandom_range(0, 131072000)) - 65536000),
                                   23'($urandom_range(13107, 6553600)),
                                   23'($urandom_range(1, 6553600)),
                                   23'($urandom_range(0, 6553600)));
            endcase
            no_idle = (ph % 3 == 1);
            for (int i = 0; i < PHASE_N; i++)
            begin
                // fill the pipeline against a long hold-off
                if (ph == 4 && i == 10)
                    hold_req = 1'b1;
                // pause mid-phase until every result is back
                if (ph == 5 && i == PHASE_N / 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                send_random();
            end
            drain();
        end

        $display("covered %0d results over a range of register settings, incl. zero time",
                 checked);
        $display("constants, saturation, negative model, nonpositive and zero-sigma inputs");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lcr_pkg.sv
rtl/core/lcr_div_pipe.sv
rtl/core/lcr_exp_pipe.sv
rtl/core/light_curve_residual_unit.sv
tb/light_curve_residual_checker.sv
tb/tb.sv
